// ===== hw/rtl/rmq_pkg.sv =====
// rmq_pkg: widths, branch codes and shared types for the rotation matrix to
// quaternion converter. No dependencies.
package rmq_pkg;

   localparam int FRAC_BITS = 14;
   localparam int DATA_W    = 16;
   // trace of three elements
   localparam int T_W       = DATA_W + 2;
   // radicand never exceeds 2^F + 3 * 2^(DATA_W-1) - 1
   localparam int RAD_W     = $clog2((1 << FRAC_BITS) + 3 * (1 << (DATA_W - 1)));
   localparam int RE_W      = RAD_W + 2;
   localparam int X_W       = RAD_W + FRAC_BITS + 2;
   localparam int XP_W      = X_W + (X_W % 2);
   localparam int SQ_W      = XP_W / 2;
   localparam int SR_W      = SQ_W + 1;
   localparam int MAG_W     = DATA_W + 1;
   localparam int NUM_W     = FRAC_BITS + DATA_W + 2;
   localparam int Q_W       = DATA_W;
   localparam int DR_W      = SQ_W + 1;
   localparam int LANES     = 4;
   localparam int BR_W      = 2;

   localparam int Q_POS_MAX = (1 << (DATA_W - 1)) - 1;
   localparam int Q_NEG_MAX = 1 << (DATA_W - 1);

   // lane order of the quaternion
   localparam int LANE_X = 0;
   localparam int LANE_Y = 1;
   localparam int LANE_Z = 2;
   localparam int LANE_W = 3;

   localparam logic [BR_W-1:0] BR_TRACE = 2'd0;
   localparam logic [BR_W-1:0] BR_X     = 2'd1;
   localparam logic [BR_W-1:0] BR_Y     = 2'd2;
   localparam logic [BR_W-1:0] BR_Z     = 2'd3;

   // per-lane numerator magnitude and sign, plus the branch
   typedef struct packed {
      logic [BR_W-1:0]              br;
      logic [LANES-1:0][MAG_W-1:0]  mag;
      logic [LANES-1:0]             neg;
   } side_type;

   typedef struct packed {
      logic [BR_W-1:0]             br;
      logic [LANES-1:0]            neg;
      logic [Q_W-1:0]              qmain;
      logic [LANES-1:0][Q_W-1:0]   q;
   } div_res_type;

endpackage

// ===== hw/rtl/rmq_front.sv =====
// rmq_front: trace, branch choice, radicand and off-diagonal numerators.
// Two register stages. Uses rmq_pkg.
module rmq_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               in_valid,
   input  logic signed [rmq_pkg::DATA_W-1:0]  m00,
   input  logic signed [rmq_pkg::DATA_W-1:0]  m01,
   input  logic signed [rmq_pkg::DATA_W-1:0]  m02,
   input  logic signed [rmq_pkg::DATA_W-1:0]  m10,
   input  logic signed [rmq_pkg::DATA_W-1:0]  m11,
   input  logic signed [rmq_pkg::DATA_W-1:0]  m12,
   input  logic signed [rmq_pkg::DATA_W-1:0]  m20,
   input  logic signed [rmq_pkg::DATA_W-1:0]  m21,
   input  logic signed [rmq_pkg::DATA_W-1:0]  m22,
   output logic                               out_valid,
   output logic [rmq_pkg::RAD_W-1:0]          out_rad,
   output rmq_pkg::side_type                  out_side
);
   import rmq_pkg::*;

   localparam int P_W1  = 0;  // m21 - m12
   localparam int P_W2  = 1;  // m02 - m20
   localparam int P_W3  = 2;  // m10 - m01
   localparam int P_S01 = 3;  // m01 + m10
   localparam int P_S02 = 4;  // m02 + m20
   localparam int P_S12 = 5;  // m12 + m21
   localparam int NPAIR = 6;

   localparam logic signed [RE_W-1:0] ONE = RE_W'(1 << FRAC_BITS);

   logic                      v1_ff;
   logic signed [T_W-1:0]     t_ff, t_in;
   logic signed [DATA_W-1:0]  d00_ff, d11_ff, d22_ff;
   logic signed [T_W-1:0]     pair_ff [NPAIR];
   logic signed [T_W-1:0]     pair_in [NPAIR];

   logic                      v2_ff;
   logic [RAD_W-1:0]          rad_ff, rad_in;
   side_type                  side_ff, side_in;

   logic [BR_W-1:0]           br;
   logic signed [DATA_W-1:0]  dsel;
   logic signed [RE_W-1:0]    rad_full;
   logic signed [T_W-1:0]     lane_d [LANES];

   always_comb begin
      t_in = T_W'(m00) + T_W'(m11) + T_W'(m22);
      pair_in[P_W1]  = T_W'(m21) - T_W'(m12);
      pair_in[P_W2]  = T_W'(m02) - T_W'(m20);
      pair_in[P_W3]  = T_W'(m10) - T_W'(m01);
      pair_in[P_S01] = T_W'(m01) + T_W'(m10);
      pair_in[P_S02] = T_W'(m02) + T_W'(m20);
      pair_in[P_S12] = T_W'(m12) + T_W'(m21);
   end

   always_comb begin
      if (t_ff > 0) begin
         br = BR_TRACE;
      end else if (d00_ff > d11_ff && d00_ff > d22_ff) begin
         br = BR_X;
      end else if (d11_ff > d22_ff) begin
         br = BR_Y;
      end else begin
         br = BR_Z;
      end

      dsel = d22_ff;
      for (int l = 0; l < LANES; l++) lane_d[l] = '0;
      unique case (br)
         BR_TRACE: begin
            lane_d[LANE_X] = pair_ff[P_W1];
            lane_d[LANE_Y] = pair_ff[P_W2];
            lane_d[LANE_Z] = pair_ff[P_W3];
         end
         BR_X: begin
            dsel = d00_ff;
            lane_d[LANE_W] = pair_ff[P_W1];
            lane_d[LANE_Y] = pair_ff[P_S01];
            lane_d[LANE_Z] = pair_ff[P_S02];
         end
         BR_Y: begin
            dsel = d11_ff;
            lane_d[LANE_W] = pair_ff[P_W2];
            lane_d[LANE_X] = pair_ff[P_S01];
            lane_d[LANE_Z] = pair_ff[P_S12];
         end
         default: begin
            lane_d[LANE_W] = pair_ff[P_W3];
            lane_d[LANE_X] = pair_ff[P_S02];
            lane_d[LANE_Y] = pair_ff[P_S12];
         end
      endcase

      if (br == BR_TRACE) begin
         rad_full = RE_W'(t_ff) + ONE;
      end else begin
         rad_full = ONE + (RE_W'(dsel) <<< 1) - RE_W'(t_ff);
      end
      rad_in = RAD_W'(rad_full);

      side_in.br = br;
      for (int l = 0; l < LANES; l++) begin
         side_in.neg[l] = lane_d[l][T_W-1];
         side_in.mag[l] = MAG_W'(lane_d[l][T_W-1] ? -lane_d[l] : lane_d[l]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff    <= t_in;
         d00_ff  <= m00;
         d11_ff  <= m11;
         d22_ff  <= m22;
         pair_ff <= pair_in;
         rad_ff  <= rad_in;
         side_ff <= side_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_rad   = rad_ff;
   assign out_side  = side_ff;

endmodule

// ===== hw/rtl/rmq_sqrt.sv =====
// rmq_sqrt: pipelined restoring integer square root, one root bit per stage.
// Carries the lane numerators alongside. Uses rmq_pkg.
module rmq_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic [rmq_pkg::RAD_W-1:0]  in_rad,
   input  rmq_pkg::side_type          in_side,
   output logic                       out_valid,
   output logic [rmq_pkg::SQ_W-1:0]   out_root,
   output rmq_pkg::side_type          out_side
);
   import rmq_pkg::*;

   logic [SQ_W-1:0]  v_ff;
   logic [XP_W-1:0]  x_ff    [SQ_W];
   logic [SQ_W-1:0]  root_ff [SQ_W];
   logic [SR_W-1:0]  rem_ff  [SQ_W];
   side_type         side_ff [SQ_W];

   logic [SQ_W-1:0]  v_prev;
   logic [XP_W-1:0]  x_prev    [SQ_W];
   logic [SQ_W-1:0]  root_prev [SQ_W];
   logic [SR_W-1:0]  rem_prev  [SQ_W];
   side_type         side_prev [SQ_W];

   always_comb begin
      v_prev[0]    = in_valid;
      x_prev[0]    = XP_W'(in_rad) << (FRAC_BITS + 2);
      root_prev[0] = '0;
      rem_prev[0]  = '0;
      side_prev[0] = in_side;
      for (int k = 1; k < SQ_W; k++) begin
         v_prev[k]    = v_ff[k-1];
         x_prev[k]    = x_ff[k-1];
         root_prev[k] = root_ff[k-1];
         rem_prev[k]  = rem_ff[k-1];
         side_prev[k] = side_ff[k-1];
      end
   end

   for (genvar k = 0; k < SQ_W; k++) begin : g_step
      logic [SR_W+1:0] rem_sh;
      logic [SR_W+1:0] trial;
      logic            fit;
      logic [SQ_W-1:0] root_in;
      logic [SR_W-1:0] rem_in;

      always_comb begin
         rem_sh  = {rem_prev[k], x_prev[k][XP_W-1 -: 2]};
         trial   = (SR_W + 2)'({root_prev[k], 2'b01});
         fit     = rem_sh >= trial;
         root_in = {root_prev[k][SQ_W-2:0], fit};
         rem_in  = fit ? SR_W'(rem_sh - trial) : SR_W'(rem_sh);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_prev[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[k]    <= x_prev[k] << 2;
            root_ff[k] <= root_in;
            rem_ff[k]  <= rem_in;
            side_ff[k] <= side_prev[k];
         end
      end
   end

   assign out_valid = v_ff[SQ_W-1];
   assign out_root  = root_ff[SQ_W-1];
   assign out_side  = side_ff[SQ_W-1];

endmodule

// ===== hw/rtl/rmq_div.sv =====
// rmq_div: four-lane pipelined restoring divider (rounded numerator over S),
// one quotient bit per stage, plus the S/4 component. Uses rmq_pkg.
module rmq_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  logic [rmq_pkg::SQ_W-1:0]  in_root,
   input  rmq_pkg::side_type         in_side,
   output logic                      out_valid,
   output rmq_pkg::div_res_type      out_res
);
   import rmq_pkg::*;

   localparam int NSTG = Q_W + 1;

   typedef struct packed {
      logic [SQ_W-1:0]              s;
      logic [LANES-1:0][DR_W-1:0]   rem;
      logic [LANES-1:0][Q_W-1:0]    nq;
      logic [BR_W-1:0]              br;
      logic [LANES-1:0]             neg;
      logic [Q_W-1:0]               qmain;
   } dstage_type;

   logic [NSTG-1:0]  v_ff;
   dstage_type       st_ff [NSTG];
   dstage_type       st_in [NSTG];

   logic [NUM_W-1:0] num [LANES];
   logic [SQ_W:0]    qsum;
   logic [SQ_W:0]    qshift;

   // stage 0: rounded numerator and the S/4 term
   always_comb begin
      qsum   = (SQ_W + 1)'(in_root) + (SQ_W + 1)'(2);
      qshift = qsum >> 2;
      st_in[0].s     = in_root;
      st_in[0].br    = in_side.br;
      st_in[0].neg   = in_side.neg;
      st_in[0].qmain = (qshift > (SQ_W + 1)'(Q_POS_MAX)) ? Q_W'(Q_POS_MAX) : Q_W'(qshift);
      for (int l = 0; l < LANES; l++) begin
         num[l] = (NUM_W'(in_side.mag[l]) << FRAC_BITS) + NUM_W'(in_root >> 1);
         // upper part is already below S since the quotient fits Q_W bits
         st_in[0].rem[l] = DR_W'(num[l] >> Q_W);
         st_in[0].nq[l]  = num[l][Q_W-1:0];
      end
   end

   for (genvar k = 1; k < NSTG; k++) begin : g_step
      logic [DR_W-1:0] r2  [LANES];
      logic [LANES-1:0] fit;

      always_comb begin
         st_in[k] = st_ff[k-1];
         for (int l = 0; l < LANES; l++) begin
            r2[l]  = {st_ff[k-1].rem[l][DR_W-2:0], st_ff[k-1].nq[l][Q_W-1]};
            fit[l] = r2[l] >= DR_W'(st_ff[k-1].s);
            st_in[k].rem[l] = fit[l] ? r2[l] - DR_W'(st_ff[k-1].s) : r2[l];
            st_in[k].nq[l]  = {st_ff[k-1].nq[l][Q_W-2:0], fit[l]};
         end
      end
   end

   for (genvar k = 0; k < NSTG; k++) begin : g_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= (k == 0) ? in_valid : v_ff[(k == 0) ? 0 : k - 1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign out_valid     = v_ff[NSTG-1];
   assign out_res.br    = st_ff[NSTG-1].br;
   assign out_res.neg   = st_ff[NSTG-1].neg;
   assign out_res.qmain = st_ff[NSTG-1].qmain;
   assign out_res.q     = st_ff[NSTG-1].nq;

endmodule

// ===== hw/rtl/rotation_matrix_to_quaternion.sv =====
// Rotation matrix to unit quaternion converter, top level.
// Depends on rmq_pkg, rmq_front, rmq_sqrt and rmq_div.
//
// Takes a 3x3 rotation matrix in signed Q1.14 and returns the quaternion
// x, y, z, w in signed Q1.14, saturated, with a branch code (0 positive trace,
// 1 x largest, 2 y largest, 3 z largest). One matrix may be accepted every
// clock while req_stall is low. The path has 37 register stages: two for trace
// and branch logic, 17 for the square root (one root bit per stage), 17 for the
// four-lane divider (numerator setup, then one quotient bit per stage) and one
// for saturation.
// A two-entry output (result register plus skid register) lets one more
// transfer in after the result side stalls; the pipeline then holds.
module rotation_matrix_to_quaternion (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [rmq_pkg::DATA_W-1:0]  req_m00,
   input  logic signed [rmq_pkg::DATA_W-1:0]  req_m01,
   input  logic signed [rmq_pkg::DATA_W-1:0]  req_m02,
   input  logic signed [rmq_pkg::DATA_W-1:0]  req_m10,
   input  logic signed [rmq_pkg::DATA_W-1:0]  req_m11,
   input  logic signed [rmq_pkg::DATA_W-1:0]  req_m12,
   input  logic signed [rmq_pkg::DATA_W-1:0]  req_m20,
   input  logic signed [rmq_pkg::DATA_W-1:0]  req_m21,
   input  logic signed [rmq_pkg::DATA_W-1:0]  req_m22,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [rmq_pkg::DATA_W-1:0]  rsp_quat_x,
   output logic signed [rmq_pkg::DATA_W-1:0]  rsp_quat_y,
   output logic signed [rmq_pkg::DATA_W-1:0]  rsp_quat_z,
   output logic signed [rmq_pkg::DATA_W-1:0]  rsp_quat_w,
   output logic [rmq_pkg::BR_W-1:0]           rsp_branch_taken
);
   import rmq_pkg::*;

   typedef struct packed {
      logic [LANES-1:0][DATA_W-1:0] quat;
      logic [BR_W-1:0]              br;
   } rsp_type;

   logic             en;
   logic             fr_valid;
   logic [RAD_W-1:0] fr_rad;
   side_type         fr_side;
   logic             sq_valid;
   logic [SQ_W-1:0]  sq_root;
   side_type         sq_side;
   logic             dv_valid;
   div_res_type      dv_res;

   logic             out_v_ff;
   rsp_type          out_ff, out_in;
   logic             skid_full_ff;
   rsp_type          skid_ff;
   rsp_type          rsp_data;
   int               main_lane;

   // pipeline moves whenever the skid register is free
   assign en        = !skid_full_ff;
   assign req_stall = skid_full_ff;

   rmq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .m00       (req_m00),
      .m01       (req_m01),
      .m02       (req_m02),
      .m10       (req_m10),
      .m11       (req_m11),
      .m12       (req_m12),
      .m20       (req_m20),
      .m21       (req_m21),
      .m22       (req_m22),
      .out_valid (fr_valid),
      .out_rad   (fr_rad),
      .out_side  (fr_side)
   );

   rmq_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fr_valid),
      .in_rad    (fr_rad),
      .in_side   (fr_side),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   rmq_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .in_root   (sq_root),
      .in_side   (sq_side),
      .out_valid (dv_valid),
      .out_res   (dv_res)
   );

   // pick the S/4 lane, apply sign and saturate the others
   always_comb begin
      unique case (dv_res.br)
         BR_TRACE: main_lane = LANE_W;
         BR_X:     main_lane = LANE_X;
         BR_Y:     main_lane = LANE_Y;
         default:  main_lane = LANE_Z;
      endcase
      out_in.br = dv_res.br;
      for (int l = 0; l < LANES; l++) begin
         if (l == main_lane) begin
            out_in.quat[l] = DATA_W'(dv_res.qmain);
         end else if (dv_res.neg[l]) begin
            out_in.quat[l] = (dv_res.q[l] > Q_W'(Q_NEG_MAX)) ? DATA_W'(Q_NEG_MAX)
                                                               : DATA_W'(-dv_res.q[l]);
         end else begin
            out_in.quat[l] = (dv_res.q[l] > Q_W'(Q_POS_MAX)) ? DATA_W'(Q_POS_MAX)
                                                               : DATA_W'(dv_res.q[l]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff     <= 1'b0;
         skid_full_ff <= 1'b0;
      end else begin
         if (en) begin
            out_v_ff <= dv_valid;
         end
         if (skid_full_ff && !rsp_stall) begin
            skid_full_ff <= 1'b0;
         end else if (!skid_full_ff && out_v_ff && rsp_stall) begin
            skid_full_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
      // park the stalled result so the pipeline can step once more
      if (!skid_full_ff && out_v_ff && rsp_stall) begin
         skid_ff <= out_ff;
      end
   end

   assign rsp_data         = skid_full_ff ? skid_ff : out_ff;
   assign rsp_valid        = skid_full_ff | out_v_ff;
   assign rsp_quat_x       = rsp_data.quat[LANE_X];
   assign rsp_quat_y       = rsp_data.quat[LANE_Y];
   assign rsp_quat_z       = rsp_data.quat[LANE_Z];
   assign rsp_quat_w       = rsp_data.quat[LANE_W];
   assign rsp_branch_taken = rsp_data.br;

endmodule
